// File: hw/rtl/rle_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rle_pkg
// Types and constants shared by the run-length image to display stream block.
// ----------------------------------------------------------------------------
package rle_pkg;

    typedef enum logic [1:0] {
        KIND_CMD    = 2'd0,
        KIND_PARAM  = 2'd1,
        KIND_PIXELS = 2'd2
    } t_item_kind;

    // Position of a word inside the output burst caused by one run.
    typedef enum logic [3:0] {
        SLOT_COL_CMD = 4'd0,
        SLOT_XS_HI   = 4'd1,
        SLOT_XS_LO   = 4'd2,
        SLOT_XE_HI   = 4'd3,
        SLOT_XE_LO   = 4'd4,
        SLOT_ROW_CMD = 4'd5,
        SLOT_YS_HI   = 4'd6,
        SLOT_YS_LO   = 4'd7,
        SLOT_YE_HI   = 4'd8,
        SLOT_YE_LO   = 4'd9,
        SLOT_MEM_CMD = 4'd10,
        SLOT_PIXELS  = 4'd11
    } t_slot;

    typedef enum logic [3:0] {
        REG_X_ORIGIN     = 4'd0,
        REG_Y_ORIGIN     = 4'd1,
        REG_IMAGE_WIDTH  = 4'd2,
        REG_IMAGE_HEIGHT = 4'd3
    } t_reg_index;

    localparam logic [7:0]  CMD_COLUMN_SET   = 8'h2A;
    localparam logic [7:0]  CMD_ROW_SET      = 8'h2B;
    localparam logic [7:0]  CMD_MEMORY_WRITE = 8'h2C;
    localparam logic [7:0]  BYTE_MASK        = 8'hFF;

    localparam logic [15:0] RST_X_ORIGIN     = 16'd0;
    localparam logic [15:0] RST_Y_ORIGIN     = 16'd0;
    localparam logic [15:0] RST_IMAGE_WIDTH  = 16'd70;
    localparam logic [15:0] RST_IMAGE_HEIGHT = 16'd70;

    typedef struct packed {
        logic [7:0]  run_length;
        logic [15:0] run_color;
    } t_run_in;

    typedef struct packed {
        t_item_kind  item_kind;
        logic [7:0]  bus_byte;
        logic [15:0] pixel_color;
        logic [7:0]  pixel_count;
        logic        image_done;
        logic        last;
    } t_lcd_out;

    // One accepted run together with the window it opens, if any.
    typedef struct packed {
        logic [7:0]  run_length;
        logic [15:0] run_color;
        logic        image_done;
        logic [15:0] x_start;
        logic [15:0] x_end;
        logic [15:0] y_cur;
    } t_run_job;

endpackage

// File: hw/rtl/rle_item_fmt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rle_item_fmt
// Builds the output word for one position of a run's burst.
// ----------------------------------------------------------------------------
module rle_item_fmt (
    input  rle_pkg::t_run_job i_job,
    input  rle_pkg::t_slot    i_slot,
    output rle_pkg::t_lcd_out o_item
);
    import rle_pkg::*;

    always_comb begin
        o_item             = '0;
        o_item.item_kind   = KIND_PARAM;
        case (i_slot)
            SLOT_COL_CMD: begin
                o_item.item_kind = KIND_CMD;
                o_item.bus_byte  = CMD_COLUMN_SET;
            end
            SLOT_XS_HI: o_item.bus_byte = i_job.x_start[15:8];
            SLOT_XS_LO: o_item.bus_byte = i_job.x_start[7:0] & BYTE_MASK;
            SLOT_XE_HI: o_item.bus_byte = i_job.x_end[15:8];
            SLOT_XE_LO: o_item.bus_byte = i_job.x_end[7:0] & BYTE_MASK;
            SLOT_ROW_CMD: begin
                o_item.item_kind = KIND_CMD;
                o_item.bus_byte  = CMD_ROW_SET;
            end
            SLOT_YS_HI: o_item.bus_byte = i_job.y_cur[15:8];
            SLOT_YS_LO: o_item.bus_byte = i_job.y_cur[7:0] & BYTE_MASK;
            SLOT_YE_HI: o_item.bus_byte = i_job.y_cur[15:8];
            SLOT_YE_LO: o_item.bus_byte = i_job.y_cur[7:0] & BYTE_MASK;
            SLOT_MEM_CMD: begin
                o_item.item_kind = KIND_CMD;
                o_item.bus_byte  = CMD_MEMORY_WRITE;
            end
            SLOT_PIXELS: begin
                o_item.item_kind   = KIND_PIXELS;
                o_item.pixel_color = i_job.run_color;
                o_item.pixel_count = i_job.run_length;
                o_item.image_done  = i_job.image_done;
                o_item.last        = 1'b1;
            end
            default: begin
                o_item.item_kind = KIND_CMD;
            end
        endcase
    end

endmodule

// File: hw/rtl/rle_image_to_lcd_stream_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rle_image_to_lcd_stream_unit
// Turns run-length image runs into a display-controller word stream.
// ----------------------------------------------------------------------------
// Usage: runs enter on the input channel (valid/ready), one word each, as a
// repeat count and a color. Words leave on the output channel: a run that
// starts a row is preceded by eleven address-window words (column set, start
// and end column, row set, the row twice, memory write); every run then
// gives one pixel-run word, which carries last and, for the run that closes
// the final row, image_done.
// Each accepted run waits in the job register; its words leave through the
// single output register at one word per cycle while the receiver keeps
// ready high. A mid-row run gives one word, a row-opening run twelve.
// A new run is accepted in the cycle its predecessor's last word is loaded,
// so runs flow back to back while the receiver keeps ready high.
// When the receiver stalls, the output word holds and one accepted run waits
// in the job register; input ready drops until that run can move on.
// Reset clears the row counters and loads the register defaults (origin 0,
// 70 by 70 pixels). Configuration writes are always taken and should be
// issued only while no run is in flight.
// ----------------------------------------------------------------------------
module rle_image_to_lcd_stream_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  rle_pkg::t_run_in  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output rle_pkg::t_lcd_out o_out_data,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [3:0]        i_cfg_index,
    input  logic [15:0]       i_cfg_data
);
    import rle_pkg::*;

    logic [15:0] r_x_origin, r_y_origin, r_image_width, r_image_height;
    logic [15:0] r_row_index, n_row_index;
    logic [16:0] r_pixels_in_row, n_pixels_in_row;
    logic        r_row_open, n_row_open;

    logic        r_job_valid;
    t_run_job    r_job, n_job;
    t_slot       r_slot, n_slot;

    logic        r_out_valid;
    t_lcd_out    r_out_data;
    t_lcd_out    fmt_item;

    logic        out_load, job_emit, job_finish, in_accept;
    logic [16:0] pix_sum;
    logic [16:0] next_row;
    logic        row_close;

    assign o_cfg_ready = 1'b1;
    assign out_load    = !r_out_valid || i_out_ready;
    assign job_emit    = r_job_valid && out_load;
    assign job_finish  = job_emit && (r_slot == SLOT_PIXELS);
    assign o_in_ready  = !r_job_valid || job_finish;
    assign in_accept   = i_in_valid && o_in_ready;

    // Row bookkeeping is settled at accept time; the job register then only
    // carries what the burst needs.
    always_comb begin
        pix_sum         = r_pixels_in_row + {9'd0, i_in_data.run_length};
        row_close       = pix_sum >= {1'b0, r_image_width};
        next_row        = {1'b0, r_row_index} + 17'd1;
        n_row_index     = r_row_index;
        n_pixels_in_row = pix_sum;
        n_row_open      = 1'b1;
        n_job.run_length = i_in_data.run_length;
        n_job.run_color  = i_in_data.run_color;
        n_job.image_done = 1'b0;
        n_job.x_start    = r_x_origin;
        n_job.x_end      = r_x_origin + r_image_width - 16'd1;
        n_job.y_cur      = r_y_origin + r_row_index;
        n_slot           = r_row_open ? SLOT_PIXELS : SLOT_COL_CMD;
        if (row_close) begin
            n_row_open      = 1'b0;
            n_pixels_in_row = '0;
            if (next_row >= {1'b0, r_image_height}) begin
                n_job.image_done = 1'b1;
                n_row_index      = '0;
            end else begin
                n_row_index = next_row[15:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_origin     <= RST_X_ORIGIN;
            r_y_origin     <= RST_Y_ORIGIN;
            r_image_width  <= RST_IMAGE_WIDTH;
            r_image_height <= RST_IMAGE_HEIGHT;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_X_ORIGIN:     r_x_origin     <= i_cfg_data;
                REG_Y_ORIGIN:     r_y_origin     <= i_cfg_data;
                REG_IMAGE_WIDTH:  r_image_width  <= i_cfg_data;
                REG_IMAGE_HEIGHT: r_image_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_index     <= '0;
            r_pixels_in_row <= '0;
            r_row_open      <= 1'b0;
            r_job_valid     <= 1'b0;
            r_slot          <= SLOT_COL_CMD;
            r_out_valid     <= 1'b0;
        end else begin
            if (in_accept) begin
                r_row_index     <= n_row_index;
                r_pixels_in_row <= n_pixels_in_row;
                r_row_open      <= n_row_open;
                r_job_valid     <= 1'b1;
                r_slot          <= n_slot;
            end else if (job_finish) begin
                r_job_valid <= 1'b0;
            end else if (job_emit) begin
                r_slot <= t_slot'(r_slot + 4'd1);
            end
            if (out_load) begin
                r_out_valid <= r_job_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_job <= n_job;
        end
        if (job_emit) begin
            r_out_data <= fmt_item;
        end
    end

    rle_item_fmt u_fmt (
        .i_job  (r_job),
        .i_slot (r_slot),
        .o_item (fmt_item)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the run-length image to display stream unit.
// Runs go in through a valid/ready channel, and a behavioral copy of the row
// and window logic predicts every output word. A checker compares each word
// that leaves the block, field by field, against the oldest prediction.
// Directed cases cover register extremes, coordinate wrap, zero-length and
// overshooting runs, changes of width and height part way through an image,
// and ignored register indexes. Random images follow, under changing
// back-pressure and with one long output stall.
// ----------------------------------------------------------------------------
module tb;
    import rle_pkg::*;

    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned STALL_LIMIT = 4000;
    localparam int unsigned TAIL_CYCLES = 16;

    logic     i_clk;
    logic     i_rst_n;
    logic     i_in_valid;
    logic     o_in_ready;
    t_run_in  i_in_data;
    logic     o_out_valid;
    logic     i_out_ready;
    t_lcd_out o_out_data;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [3:0]  i_cfg_index;
    logic [15:0] i_cfg_data;

    rle_image_to_lcd_stream_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Register copies and row state of the predictor.
    logic [15:0] cfg_x_origin;
    logic [15:0] cfg_y_origin;
    logic [15:0] cfg_width;
    logic [15:0] cfg_height;
    logic [15:0] row_idx;
    logic [16:0] row_pixels;
    logic        row_is_open;

    t_lcd_out    lcd_words_due[$];
    int unsigned mismatch_cnt;
    int unsigned snd_idle_pct;
    int unsigned rcv_idle_pct;
    bit          hold_req;
    int unsigned quiet_cycles;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic void push_lcd_word(t_item_kind kind, logic [7:0] bus_v,
                                          logic [15:0] color, logic [7:0] count,
                                          logic done, logic fin);
        t_lcd_out w;
        w.item_kind   = kind;
        w.bus_byte    = bus_v;
        w.pixel_color = color;
        w.pixel_count = count;
        w.image_done  = done;
        w.last        = fin;
        lcd_words_due.push_back(w);
    endfunction

    function automatic void push_param_pair(logic [15:0] value);
        push_lcd_word(KIND_PARAM, value[15:8], 16'h0, 8'h0, 1'b0, 1'b0);
        push_lcd_word(KIND_PARAM, value[7:0], 16'h0, 8'h0, 1'b0, 1'b0);
    endfunction

    // Works out the words one accepted run causes and advances the row state.
    function automatic void derive_lcd_words(logic [7:0] len, logic [15:0] color);
        logic [15:0] x_end;
        logic [15:0] y_cur;
        logic [16:0] next_row;
        logic        done;
        done = 1'b0;
        if (!row_is_open) begin
            x_end = cfg_x_origin + cfg_width - 16'd1;
            y_cur = cfg_y_origin + row_idx;
            push_lcd_word(KIND_CMD, CMD_COLUMN_SET, 16'h0, 8'h0, 1'b0, 1'b0);
            push_param_pair(cfg_x_origin);
            push_param_pair(x_end);
            push_lcd_word(KIND_CMD, CMD_ROW_SET, 16'h0, 8'h0, 1'b0, 1'b0);
            push_param_pair(y_cur);
            push_param_pair(y_cur);
            push_lcd_word(KIND_CMD, CMD_MEMORY_WRITE, 16'h0, 8'h0, 1'b0, 1'b0);
            row_is_open = 1'b1;
        end
        row_pixels = row_pixels + {9'd0, len};
        if (row_pixels >= {1'b0, cfg_width}) begin
            next_row    = {1'b0, row_idx} + 17'd1;
            row_is_open = 1'b0;
            row_pixels  = '0;
            if (next_row >= {1'b0, cfg_height}) begin
                done    = 1'b1;
                row_idx = '0;
            end else begin
                row_idx = next_row[15:0];
            end
        end
        push_lcd_word(KIND_PIXELS, 8'h0, color, len, done, 1'b1);
    endfunction

    function automatic void check_field(string name, logic [15:0] exp_v,
                                        logic [15:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            mismatch_cnt++;
        end
    endfunction

    // Output checker.
    always @(posedge i_clk) begin
        t_lcd_out w;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (lcd_words_due.size() == 0) begin
                $error("word with no prediction waiting: 0x%0h", o_out_data);
                mismatch_cnt++;
            end else begin
                w = lcd_words_due.pop_front();
                check_field("item_kind", 16'(w.item_kind), 16'(o_out_data.item_kind));
                check_field("bus_byte", 16'(w.bus_byte), 16'(o_out_data.bus_byte));
                check_field("pixel_color", w.pixel_color, o_out_data.pixel_color);
                check_field("pixel_count", 16'(w.pixel_count),
                            16'(o_out_data.pixel_count));
                check_field("image_done", 16'(w.image_done), 16'(o_out_data.image_done));
                check_field("last", 16'(w.last), 16'(o_out_data.last));
            end
        end
    end

    // Receiver: random ready, with an occasional long hold-off on request.
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end
            i_out_ready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    // Watchdog on cycles in which no channel moves a word.
    initial begin
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
                (i_cfg_valid && o_cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    // Returns at a falling edge with valid still high, so that the next run can
    // follow back to back; anything else must call wait_idle first.
    task automatic send_run(input logic [7:0] len, input logic [15:0] color);
        t_run_in run;
        run.run_length = len;
        run.run_color  = color;
        while ($urandom_range(99) < snd_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= run;
        do @(posedge i_clk); while (!o_in_ready);
        derive_lcd_words(len, color);
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (lcd_words_due.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [3:0] idx, input logic [15:0] value);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_X_ORIGIN:     cfg_x_origin = value;
            REG_Y_ORIGIN:     cfg_y_origin = value;
            REG_IMAGE_WIDTH:  cfg_width    = value;
            REG_IMAGE_HEIGHT: cfg_height   = value;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // Exact fill, a zero-length run that only opens a row, and an overshoot.
    task automatic test_reset_defaults();
        send_run(8'd70, 16'hFFFF);
        send_run(8'd0, 16'h0000);
        send_run(8'd255, 16'h1234);
    endtask

    // Column end and row address wrap; width shrinks while a row is open.
    task automatic test_origin_wrap();
        write_reg(REG_X_ORIGIN, 16'hFFFF);
        write_reg(REG_Y_ORIGIN, 16'hFFFF);
        write_reg(REG_IMAGE_WIDTH, 16'hFFFF);
        send_run(8'd255, 16'h8001);
        send_run(8'd0, 16'h7FFE);
        write_reg(REG_IMAGE_WIDTH, 16'd1);
        send_run(8'd0, 16'h00FF);
    endtask

    task automatic test_single_row_image();
        write_reg(REG_IMAGE_HEIGHT, 16'd1);
        send_run(8'd1, 16'hF00F);
        send_run(8'd0, 16'h0FF0);
        send_run(8'd200, 16'h5A5A);
        write_reg(REG_X_ORIGIN, 16'h0000);
        write_reg(REG_Y_ORIGIN, 16'h0000);
    endtask

    // Height drops below the current row, so the next close ends the image.
    task automatic test_shrunken_height();
        write_reg(REG_IMAGE_WIDTH, 16'd4);
        write_reg(REG_IMAGE_HEIGHT, 16'd10);
        repeat (3) send_run(8'd4, 16'($urandom));
        write_reg(REG_IMAGE_HEIGHT, 16'd2);
        send_run(8'd4, 16'hC3C3);
        send_run(8'd5, 16'h3C3C);
    endtask

    task automatic test_ignored_index();
        write_reg(REG_IMAGE_HEIGHT + 4'd12, 16'hFFFF);
        write_reg(REG_IMAGE_HEIGHT + 4'd1, 16'h0000);
        send_run(8'd3, 16'hA5A5);
    endtask

    task automatic test_register_extremes();
        write_reg(REG_IMAGE_WIDTH, 16'hFFFF);
        write_reg(REG_IMAGE_HEIGHT, 16'hFFFF);
        send_run(8'd255, 16'hFFFF);
        send_run(8'd0, 16'h0000);
    endtask

    // Mostly runs that build rows up to the width, with some noise lengths.
    task automatic test_random_images(input int unsigned snd_pct,
                                      input int unsigned rcv_pct);
        int unsigned span;
        int unsigned rest;
        int unsigned pick;
        logic [7:0]  len;
        snd_idle_pct = snd_pct;
        rcv_idle_pct = rcv_pct;
        for (int img = 0; img < 3; img++) begin
            write_reg(REG_X_ORIGIN, 16'($urandom));
            write_reg(REG_Y_ORIGIN, 16'($urandom));
            if ($urandom_range(3) == 0)
                write_reg(REG_IMAGE_WIDTH, 16'($urandom_range(1, 65535)));
            else
                write_reg(REG_IMAGE_WIDTH, 16'($urandom_range(1, 24)));
            write_reg(REG_IMAGE_HEIGHT, 16'($urandom_range(1, 4)));
            for (int k = 0; k < 8; k++) begin
                span = (cfg_width > 16'd255) ? 255 : 32'(cfg_width);
                rest = (row_pixels >= {1'b0, cfg_width}) ? 0 :
                       32'({1'b0, cfg_width} - row_pixels);
                if (rest > 255)
                    rest = 255;
                pick = $urandom_range(99);
                if (pick < 15)
                    len = 8'($urandom_range(0, 255));
                else if (pick < 45)
                    len = 8'(rest);
                else
                    len = 8'($urandom_range(0, span));
                send_run(len, 16'($urandom));
            end
        end
    endtask

    // The receiver holds off long enough for the block to stall its input,
    // then the sender pauses until every word has come out.
    task automatic test_output_stall();
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        write_reg(REG_IMAGE_WIDTH, 16'd8);
        write_reg(REG_IMAGE_HEIGHT, 16'd3);
        hold_req = 1'b1;
        repeat (20) send_run(8'($urandom_range(0, 10)), 16'($urandom));
        wait_idle();
        repeat (6) send_run(8'($urandom_range(0, 10)), 16'($urandom));
        wait_idle();
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_in_data    = '0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = '0;
        i_cfg_data   = '0;
        mismatch_cnt = 0;
        hold_req     = 1'b0;
        snd_idle_pct = 7;
        rcv_idle_pct = 79;
        cfg_x_origin = RST_X_ORIGIN;
        cfg_y_origin = RST_Y_ORIGIN;
        cfg_width    = RST_IMAGE_WIDTH;
        cfg_height   = RST_IMAGE_HEIGHT;
        row_idx      = '0;
        row_pixels   = '0;
        row_is_open  = 1'b0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_defaults();
        test_origin_wrap();
        test_single_row_image();
        test_shrunken_height();
        test_ignored_index();
        test_register_extremes();
        test_random_images(7, 79);
        test_random_images(79, 7);
        test_random_images(0, 0);
        test_output_stall();

        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (mismatch_cnt == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule

// File: files.f
hw/rtl/rle_pkg.sv
hw/rtl/rle_item_fmt.sv
hw/rtl/rle_image_to_lcd_stream_unit.sv
test/tb.sv
